@@ rtl/fpa_pkg.sv @@
`timescale 1ns / 1ps
package fpa_pkg;

   localparam int FIELD_BITS    = 32;
   localparam int FRAC_BITS_DEF = 8;
   localparam int WORD_BITS_DEF = 32;

   typedef enum logic [3:0] {
      MODE_ADD     = 4'd0,
      MODE_SUB     = 4'd1,
      MODE_MUL     = 4'd2,
      MODE_DIV     = 4'd3,
      MODE_GT      = 4'd4,
      MODE_LT      = 4'd5,
      MODE_GE      = 4'd6,
      MODE_LE      = 4'd7,
      MODE_EQ      = 4'd8,
      MODE_NE      = 4'd9,
      MODE_MIN     = 4'd10,
      MODE_MAX     = 4'd11,
      MODE_INC     = 4'd12,
      MODE_DEC     = 4'd13,
      MODE_TOINT   = 4'd14,
      MODE_FROMINT = 4'd15
   } mode_type;

   typedef struct packed {
      mode_type                      mode;
      logic signed [FIELD_BITS-1:0]  operand_a;
      logic signed [FIELD_BITS-1:0]  operand_b;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0]  result_value;
      logic                          condition;
      logic                          fault;
   } rsp_type;

endpackage

@@ rtl/fixed_point_q24_8_alu.sv @@
`timescale 1ns / 1ps
// Signed fixed-point ALU (Q24.8 by default). Takes one operation per cycle while
// the output is not stalled; the pipeline depth is set by the divider, which
// resolves one quotient bit per pipeline stage. Every operation travels the
// full pipe, so results come out in order. Multiply and divide round to nearest
// with ties away from zero and saturate with fault set on overflow or divide by
// zero; add, sub, inc, dec and fromint wrap silently. The whole pipe advances
// when the output stage is empty or its result is taken, so a stalled output
// holds every stage in place.
module fixed_point_q24_8_alu
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int NB = W + F;          // dividend / quotient bits
   localparam int L  = NB + 3;         // pipeline stages
   localparam int SW = 2 * W + 1;      // width handed to saturation
   localparam int HL = (W + 1) / 2;    // low half of multiplier split
   localparam int HH = W - HL;
   localparam logic [2*W-1:0] HALF = (2 * W)'(1) << (F - 1);

   // stage registers: stage 0 input, 1 prep, 2..NB+1 divide steps, L-1 output
   logic                  vld_ff   [L];
   mode_type              mode_ff  [L];
   logic signed [W-1:0]   res_ff   [L];
   logic                  cond_ff  [L];
   logic                  fault_ff [L];
   logic                  neg_ff   [L];
   logic                  aneg_ff  [L];
   logic [W-1:0]          ma_ff    [L];
   logic [W-1:0]          mb_ff    [L];
   logic [2*HL-1:0]       pll_ff   [L];
   logic [W-1:0]          plh_ff   [L];
   logic [W-1:0]          phl_ff   [L];
   logic [2*HH-1:0]       phh_ff   [L];
   logic [2*W-1:0]        prod_ff  [L];
   logic [NB-1:0]         num_ff   [L];
   logic [W:0]            rem_ff   [L];
   logic [NB-1:0]         q_ff     [L];

   logic                  vld_in   [L];
   mode_type              mode_in  [L];
   logic signed [W-1:0]   res_in   [L];
   logic                  cond_in  [L];
   logic                  fault_in [L];
   logic                  neg_in   [L];
   logic                  aneg_in  [L];
   logic [W-1:0]          ma_in    [L];
   logic [W-1:0]          mb_in    [L];
   logic [2*HL-1:0]       pll_in   [L];
   logic [W-1:0]          plh_in   [L];
   logic [W-1:0]          phl_in   [L];
   logic [2*HH-1:0]       phh_in   [L];
   logic [2*W-1:0]        prod_in  [L];
   logic [NB-1:0]         num_in   [L];
   logic [W:0]            rem_in   [L];
   logic [NB-1:0]         q_in     [L];

   logic                  move;

   // saturate a magnitude to the word limit of the given sign; {fault, value}
   function automatic logic [W:0] sat_f(input logic neg, input logic [SW-1:0] m);
      logic [SW-1:0] lim;
      logic [W-1:0]  v;
      logic          ovf;
      lim = SW'({1'b0, {(W-1){1'b1}}}) + SW'(neg);
      ovf = m > lim;
      v   = ovf ? lim[W-1:0] : m[W-1:0];
      sat_f = {ovf, neg ? W'(0) - v : v};
   endfunction

   assign move      = !vld_ff[L-1] || rsp_ready;
   assign req_ready = move;

   always_comb begin
      logic signed [W-1:0] a;
      logic signed [W-1:0] b;
      logic                lt;
      logic                gt;
      logic [W:0]          r2;
      logic                qb;
      logic                rnd;
      logic [W:0]          sf;

      // operands wrapped to the word width
      a  = W'(req_data.operand_a);
      b  = W'(req_data.operand_b);
      lt = a < b;
      gt = b < a;

      for (int s = 1; s < L; s++) begin
         vld_in[s]   = vld_ff[s-1];
         mode_in[s]  = mode_ff[s-1];
         res_in[s]   = res_ff[s-1];
         cond_in[s]  = cond_ff[s-1];
         fault_in[s] = fault_ff[s-1];
         neg_in[s]   = neg_ff[s-1];
         aneg_in[s]  = aneg_ff[s-1];
         ma_in[s]    = ma_ff[s-1];
         mb_in[s]    = mb_ff[s-1];
         pll_in[s]   = pll_ff[s-1];
         plh_in[s]   = plh_ff[s-1];
         phl_in[s]   = phl_ff[s-1];
         phh_in[s]   = phh_ff[s-1];
         prod_in[s]  = prod_ff[s-1];
         num_in[s]   = num_ff[s-1];
         rem_in[s]   = rem_ff[s-1];
         q_in[s]     = q_ff[s-1];
      end

      // stage 0: simple ops, magnitudes and signs
      vld_in[0]   = req_valid;
      mode_in[0]  = req_data.mode;
      cond_in[0]  = 1'b0;
      fault_in[0] = 1'b0;
      neg_in[0]   = a[W-1] ^ b[W-1];
      aneg_in[0]  = a[W-1];
      ma_in[0]    = a[W-1] ? W'(0) - W'(a) : W'(a);
      mb_in[0]    = b[W-1] ? W'(0) - W'(b) : W'(b);
      pll_in[0]   = '0;
      plh_in[0]   = '0;
      phl_in[0]   = '0;
      phh_in[0]   = '0;
      prod_in[0]  = '0;
      num_in[0]   = '0;
      rem_in[0]   = '0;
      q_in[0]     = '0;
      res_in[0]   = '0;
      case (req_data.mode)
         MODE_ADD:     res_in[0] = a + b;
         MODE_SUB:     res_in[0] = a - b;
         MODE_GT:      cond_in[0] = gt;
         MODE_LT:      cond_in[0] = lt;
         MODE_GE:      cond_in[0] = !lt;
         MODE_LE:      cond_in[0] = !gt;
         MODE_EQ:      cond_in[0] = a == b;
         MODE_NE:      cond_in[0] = a != b;
         MODE_MIN:     res_in[0] = lt ? a : b;
         MODE_MAX:     res_in[0] = gt ? a : b;
         MODE_INC:     res_in[0] = a + W'(1);
         MODE_DEC:     res_in[0] = a - W'(1);
         MODE_TOINT:   res_in[0] = a >>> F;
         MODE_FROMINT: res_in[0] = a << F;
         default:      res_in[0] = '0;   // mul and div fill in later
      endcase

      // stage 1: partial products, divider setup
      pll_in[1] = ma_ff[0][HL-1:0] * mb_ff[0][HL-1:0];
      plh_in[1] = ma_ff[0][HL-1:0] * mb_ff[0][W-1:HL];
      phl_in[1] = ma_ff[0][W-1:HL] * mb_ff[0][HL-1:0];
      phh_in[1] = ma_ff[0][W-1:HL] * mb_ff[0][W-1:HL];
      num_in[1] = {ma_ff[0], F'(0)};
      rem_in[1] = '0;
      q_in[1]   = '0;

      // restoring divide, one quotient bit per stage
      for (int s = 2; s <= NB + 1; s++) begin
         r2 = {rem_ff[s-1][W-1:0], num_ff[s-1][NB-1]};
         qb = r2 >= {1'b0, mb_ff[s-1]};
         rem_in[s] = qb ? r2 - {1'b0, mb_ff[s-1]} : r2;
         q_in[s]   = {q_ff[s-1][NB-2:0], qb};
         num_in[s] = {num_ff[s-1][NB-2:0], 1'b0};
      end

      // stage 2: product sum
      prod_in[2] = (2 * W)'(pll_ff[1])
                 + ((2 * W)'(plh_ff[1]) << HL)
                 + ((2 * W)'(phl_ff[1]) << HL)
                 + ((2 * W)'(phh_ff[1]) << (2 * HL));

      // stage 3: product rounding and saturation
      if (mode_ff[2] == MODE_MUL) begin
         sf = sat_f(neg_ff[2], SW'((prod_ff[2] + HALF) >> F));
         fault_in[3] = sf[W];
         res_in[3]   = sf[W-1:0];
      end

      // output stage: quotient rounding and saturation
      rnd = rem_ff[L-2] >= ({1'b0, mb_ff[L-2]} - rem_ff[L-2]);
      if (mb_ff[L-2] == '0) begin
         sf = sat_f(aneg_ff[L-2], {SW{1'b1}});
      end else begin
         sf = sat_f(neg_ff[L-2], SW'(q_ff[L-2]) + SW'(rnd));
      end
      if (mode_ff[L-2] == MODE_DIV) begin
         fault_in[L-1] = sf[W];
         res_in[L-1]   = sf[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < L; s++) vld_ff[s] <= 1'b0;
      end else if (move) begin
         for (int s = 0; s < L; s++) vld_ff[s] <= vld_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         for (int s = 0; s < L; s++) begin
            mode_ff[s]  <= mode_in[s];
            res_ff[s]   <= res_in[s];
            cond_ff[s]  <= cond_in[s];
            fault_ff[s] <= fault_in[s];
            neg_ff[s]   <= neg_in[s];
            aneg_ff[s]  <= aneg_in[s];
            ma_ff[s]    <= ma_in[s];
            mb_ff[s]    <= mb_in[s];
            pll_ff[s]   <= pll_in[s];
            plh_ff[s]   <= plh_in[s];
            phl_ff[s]   <= phl_in[s];
            phh_ff[s]   <= phh_in[s];
            prod_ff[s]  <= prod_in[s];
            num_ff[s]   <= num_in[s];
            rem_ff[s]   <= rem_in[s];
            q_ff[s]     <= q_in[s];
         end
      end
   end

   assign rsp_valid             = vld_ff[L-1];
   assign rsp_data.result_value = FIELD_BITS'(res_ff[L-1]);
   assign rsp_data.condition    = cond_ff[L-1];
   assign rsp_data.fault        = fault_ff[L-1];

endmodule

@@ rtl/fpa_checker.sv @@
`timescale 1ns / 1ps
module fpa_checker
   import fpa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // intake follows the output stage
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not track output stall");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.condition && rsp_data.fault))
      else $error("condition and fault both set");

   a_cmpzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.condition |-> rsp_data.result_value == '0)
      else $error("compare result not zero");

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
